>>> sv/alfl_pkg.sv
// Shared types and constants for the linked list block with free chain.
// Used by alfl_mem and array_linked_list_with_free_list; no dependencies.
`timescale 1ns / 1ps

package alfl_pkg;

  localparam int NODE_SLOTS = 1024;
  localparam int SLOT_W     = $clog2(NODE_SLOTS);
  localparam int STEP_W     = $clog2(NODE_SLOTS + 1);
  localparam int KEY_W      = 32;
  localparam int SLOT_OUT_W = 10;
  localparam int STATUS_W   = 2;

  typedef logic [SLOT_W-1:0]       slot_t;
  typedef logic [STEP_W-1:0]       step_t;
  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic [SLOT_OUT_W-1:0]   rsp_slot_t;
  typedef logic [STATUS_W-1:0]     status_t;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_DELETE = 1'b1;

  localparam status_t ST_DONE      = 2'd0;
  localparam status_t ST_FULL      = 2'd1;
  localparam status_t ST_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic                    func;
    logic signed [KEY_W-1:0] key;
  } req_t;

  typedef struct packed {
    status_t   status;
    rsp_slot_t slot;
  } rsp_t;

  // Node store access for one cycle: one shared read address, one write per array.
  typedef struct packed {
    logic  rd_en;
    slot_t rd_addr;
    logic  prev_we;
    slot_t prev_addr;
    slot_t prev_data;
    logic  key_we;
    slot_t key_addr;
    key_t  key_data;
    logic  next_we;
    slot_t next_addr;
    slot_t next_data;
  } mem_cmd_t;

  typedef struct packed {
    slot_t prev;
    key_t  key;
    slot_t next;
  } mem_rd_t;

  // Links out of range read as the end of the list.
  function automatic slot_t lim(input slot_t v);
    return (32'(v) < NODE_SLOTS) ? v : '0;
  endfunction

endpackage

>>> sv/alfl_mem.sv
// Node store: back links, keys and forward links, one write port each and
// a shared registered read port. Depends on alfl_pkg.
`timescale 1ns / 1ps

module alfl_mem (
  input  logic              clk,
  input  alfl_pkg::mem_cmd_t cmd,
  output alfl_pkg::mem_rd_t  rd
);

  alfl_pkg::slot_t prev_mem [alfl_pkg::NODE_SLOTS];
  alfl_pkg::key_t  key_mem  [alfl_pkg::NODE_SLOTS];
  alfl_pkg::slot_t next_mem [alfl_pkg::NODE_SLOTS];

  alfl_pkg::slot_t rd_prev;
  alfl_pkg::key_t  rd_key;
  alfl_pkg::slot_t rd_next;

  assign rd = '{prev: rd_prev, key: rd_key, next: rd_next};

  always_ff @(posedge clk) begin
    if (cmd.prev_we) begin
      prev_mem[cmd.prev_addr] <= cmd.prev_data;
    end
    if (cmd.rd_en) begin
      rd_prev <= prev_mem[cmd.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.key_we) begin
      key_mem[cmd.key_addr] <= cmd.key_data;
    end
    if (cmd.rd_en) begin
      rd_key <= key_mem[cmd.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.next_we) begin
      next_mem[cmd.next_addr] <= cmd.next_data;
    end
    if (cmd.rd_en) begin
      rd_next <= next_mem[cmd.rd_addr];
    end
  end

endmodule

>>> sv/array_linked_list_with_free_list.sv
// Insert: S_INS_RD strobes ST_FULL if the free chain is empty, else S_INS_LINK and
// S_INS_DONE follow and S_INS_DONE strobes the result. Delete reads (S_DEL_RD) and
// compares (S_DEL_CMP) each node until a miss ends the walk or a hit is unlinked in
// S_DEL_UNLINK, S_DEL_DONE. One request at a time: busy drops with the result strobe.
// Reset: synchronous; a clearing pass in S_CLEAR rebuilds the free chain in the node
// store, with busy high, before the first request is taken.
`timescale 1ns / 1ps

module array_linked_list_with_free_list (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  alfl_pkg::req_t  req,
  output logic            done,
  output alfl_pkg::rsp_t  rsp
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_INS_RD,
    S_INS_LINK,
    S_INS_DONE,
    S_DEL_RD,
    S_DEL_CMP,
    S_DEL_UNLINK,
    S_DEL_DONE
  } state_t;

  state_t             state;
  alfl_pkg::slot_t    clr_idx;
  alfl_pkg::slot_t    free_head;
  alfl_pkg::slot_t    head;
  alfl_pkg::slot_t    node;
  alfl_pkg::slot_t    p_link;
  alfl_pkg::slot_t    n_link;
  alfl_pkg::step_t    steps;
  alfl_pkg::key_t     key_q;
  alfl_pkg::mem_cmd_t cmd;
  alfl_pkg::mem_rd_t  rd;
  logic               key_hit;

  alfl_mem u_mem (
    .clk (clk),
    .cmd (cmd),
    .rd  (rd)
  );

  assign busy    = (state != S_IDLE);
  assign key_hit = (rd.key == key_q);

  always_comb begin
    cmd = '0;
    case (state)
      S_CLEAR: begin
        cmd.next_we   = 1'b1;
        cmd.next_addr = clr_idx;
        cmd.next_data = (32'(clr_idx) == alfl_pkg::NODE_SLOTS - 1) ? '0
                      : alfl_pkg::slot_t'(clr_idx + 1'b1);
      end
      S_INS_RD: begin
        cmd.rd_en   = (free_head != '0);
        cmd.rd_addr = free_head;
      end
      S_INS_LINK: begin
        cmd.prev_we   = 1'b1;
        cmd.prev_addr = node;
        cmd.prev_data = '0;
        cmd.key_we    = 1'b1;
        cmd.key_addr  = node;
        cmd.key_data  = key_q;
        cmd.next_we   = 1'b1;
        cmd.next_addr = node;
        cmd.next_data = head;
      end
      S_INS_DONE: begin
        cmd.prev_we   = 1'b1;
        cmd.prev_addr = head;
        cmd.prev_data = node;
      end
      S_DEL_RD: begin
        cmd.rd_en   = (node != '0);
        cmd.rd_addr = node;
      end
      S_DEL_UNLINK: begin
        cmd.prev_we   = 1'b1;
        cmd.prev_addr = n_link;
        cmd.prev_data = p_link;
        cmd.next_we   = 1'b1;
        cmd.next_addr = node;
        cmd.next_data = free_head;
      end
      S_DEL_DONE: begin
        // the front link lives in head, not in the store
        cmd.next_we   = (p_link != '0);
        cmd.next_addr = p_link;
        cmd.next_data = n_link;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      free_head <= alfl_pkg::slot_t'(1);
      head      <= '0;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (32'(clr_idx) == alfl_pkg::NODE_SLOTS - 1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            key_q <= req.key;
            steps <= '0;
            if (req.func == alfl_pkg::FUNC_INSERT) begin
              state <= S_INS_RD;
            end else begin
              node  <= head;
              state <= S_DEL_RD;
            end
          end
        end
        S_INS_RD: begin
          if (free_head == '0) begin
            done       <= 1'b1;
            rsp.status <= alfl_pkg::ST_FULL;
            rsp.slot   <= '0;
            state      <= S_IDLE;
          end else begin
            node  <= free_head;
            state <= S_INS_LINK;
          end
        end
        S_INS_LINK: begin
          free_head <= alfl_pkg::lim(rd.next);
          state     <= S_INS_DONE;
        end
        S_INS_DONE: begin
          head       <= node;
          done       <= 1'b1;
          rsp.status <= alfl_pkg::ST_DONE;
          rsp.slot   <= alfl_pkg::rsp_slot_t'(node);
          state      <= S_IDLE;
        end
        S_DEL_RD: begin
          if (node == '0) begin
            done       <= 1'b1;
            rsp.status <= alfl_pkg::ST_NOT_FOUND;
            rsp.slot   <= '0;
            state      <= S_IDLE;
          end else begin
            state <= S_DEL_CMP;
          end
        end
        S_DEL_CMP: begin
          if (key_hit) begin
            p_link <= alfl_pkg::lim(rd.prev);
            n_link <= alfl_pkg::lim(rd.next);
            state  <= S_DEL_UNLINK;
          end else if (32'(steps) == alfl_pkg::NODE_SLOTS) begin
            done       <= 1'b1;
            rsp.status <= alfl_pkg::ST_NOT_FOUND;
            rsp.slot   <= '0;
            state      <= S_IDLE;
          end else begin
            // advance to the next node
            node  <= alfl_pkg::lim(rd.next);
            steps <= steps + 1'b1;
            state <= S_DEL_RD;
          end
        end
        S_DEL_UNLINK: begin
          free_head <= node;
          if (p_link == '0) begin
            head <= n_link;
          end
          state <= S_DEL_DONE;
        end
        S_DEL_DONE: begin
          done       <= 1'b1;
          rsp.status <= alfl_pkg::ST_DONE;
          rsp.slot   <= alfl_pkg::rsp_slot_t'(node);
          state      <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a request in progress");

  a_slot_on_success: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status == alfl_pkg::ST_DONE) |-> (rsp.slot != '0))
    else $error("completed request reported the sentinel slot");

  a_slot_zero_on_fail: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status != alfl_pkg::ST_DONE) |-> (rsp.slot == '0))
    else $error("failed request reported a slot");
`endif

endmodule
